[hdl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int TAB_W      = 4;
  localparam int COL_FLD_W  = 7;
  localparam int ROW_FLD_W  = 5;
  localparam int POS_FLD_W  = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_ADV   = 1'd1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

endpackage

[hdl/tcw_in_if.sv]
// Input word channel: valid/ready handshake with put/read request payload.
interface tcw_in_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [CHAR_W-1:0]    char_code;
  logic                 end_of_text;
  logic [POS_FLD_W-1:0] cell_index;

  modport source (output valid, output mode, output char_code, output end_of_text,
                  output cell_index, input ready);
  modport sink   (input valid, input mode, input char_code, input end_of_text,
                  input cell_index, output ready);
endinterface

[hdl/tcw_out_if.sv]
// Result word channel: valid/ready handshake with cursor and cell payload.
interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COL_FLD_W-1:0] cursor_col;
  logic [ROW_FLD_W-1:0] cursor_row;
  logic                 scrolled;
  logic                 cursor_written;
  logic [POS_FLD_W-1:0] cursor_position;
  logic [CHAR_W-1:0]    cell_char;
  logic [ATTR_W-1:0]    cell_attr;

  modport source (output valid, output cursor_col, output cursor_row, output scrolled,
                  output cursor_written, output cursor_position, output cell_char,
                  output cell_attr, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row, input scrolled,
                  input cursor_written, input cursor_position, input cell_char,
                  input cell_attr, output ready);
endinterface

[hdl/text_console_writer.sv]
// Text console writer top level: cursor control, scroll ring and screen memory.
//
// Channels: in_if carries put/read request words, out_if carries one result
// word per request, cfg_* writes the attribute and tab registers; the user is
// to write them only while idle, and the block itself does not enforce it.
// A put word's result is registered at the edge that accepts it. A read word
// goes through the screen memory read register, then the result register;
// no word is accepted until the cell is registered into the result.
// A put that scrolls the screen advances the ring base of the row store and
// then clears the new bottom row, one cell per cycle, during which no word is
// accepted. Puts are taken one word per cycle while the receiver takes each
// result and no put scrolls. After reset the whole screen memory is cleared
// before the first word is accepted; configuration writes are taken meanwhile.
// A stalled receiver holds the result register; a new word is accepted only
// when the result register is empty or being taken in the same cycle.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tcw_in_if.sink                in_if,
  tcw_out_if.source             out_if
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int COLW  = $clog2(COLUMNS + 16);
  localparam int ROWW  = $clog2(ROWS + 1);
  localparam int SW    = ((AW > POS_FLD_W) ? AW : POS_FLD_W) + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_SCRUB = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [AW-1:0]     hw_r;
  logic [AW-1:0]     top_base_r;
  logic [AW-1:0]     sweep_addr_r;
  logic [AW-1:0]     sweep_last_r;
  logic [ATTR_W-1:0] attr_r;
  logic [TAB_W-1:0]  tab_r;
  logic              rd_zero_r;
  logic              out_valid_r;

  logic              acc_in, acc_put, acc_rd;
  logic              is_nl, is_tab, is_print;
  logic [COLW-1:0]   col_a;
  logic [ROWW-1:0]   row_a, row_b;
  logic              wrap, scroll;
  logic [CW-1:0]     col_c;
  logic [RW-1:0]     row_c;
  logic [AW-1:0]     lpos;
  logic [AW:0]       wsum;
  logic [AW-1:0]     wphys;
  logic [AW-1:0]     hw_nxt;
  logic [AW:0]       tb_sum;
  logic [AW-1:0]     top_base_nxt;
  logic [SW-1:0]     rd_sum;
  logic [AW-1:0]     rd_phys;
  logic              rd_in_range;
  logic              sweeping;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  cell_t             ram_wdata;
  cell_t             ram_rdata;

  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign acc_in      = in_if.valid && in_if.ready;
  assign acc_put     = acc_in && (in_if.mode == MODE_PUT);
  assign acc_rd      = acc_in && (in_if.mode == MODE_READ);

  assign is_nl    = (in_if.char_code == CH_NEWLINE);
  assign is_tab   = (in_if.char_code == CH_TAB);
  assign is_print = !is_nl && !is_tab;

  always_comb begin
    if (is_nl) begin
      col_a = '0;
    end else if (is_tab) begin
      col_a = COLW'(col_r) + COLW'(tab_r);
    end else begin
      col_a = COLW'(col_r) + COLW'(1);
    end
    row_a  = ROWW'(row_r) + ROWW'(is_nl);
    wrap   = (col_a >= COLUMNS);
    row_b  = row_a + ROWW'(wrap);
    scroll = (row_b >= ROWS);
    col_c  = (wrap || scroll) ? '0 : CW'(col_a);
    row_c  = scroll ? RW'(ROWS - 1) : RW'(row_b);
  end

  // ring-mapped write address of the current cursor cell
  assign lpos  = AW'(row_r * COLUMNS) + AW'(col_r);
  assign wsum  = {1'b0, lpos} + {1'b0, top_base_r};
  assign wphys = (wsum >= CELLS) ? AW'(wsum - (AW+1)'(CELLS)) : AW'(wsum);

  assign hw_nxt = AW'(row_c * COLUMNS) + AW'(col_c);

  assign tb_sum       = {1'b0, top_base_r} + (AW+1)'(COLUMNS);
  assign top_base_nxt = (tb_sum == CELLS) ? '0 : AW'(tb_sum);

  assign rd_in_range = (in_if.cell_index < CELLS);
  assign rd_sum      = SW'(in_if.cell_index) + SW'(top_base_r);
  assign rd_phys     = (rd_sum >= CELLS) ? AW'(rd_sum - SW'(CELLS)) : AW'(rd_sum);

  assign sweeping = (state_r == S_CLEAR) || (state_r == S_SCRUB);

  always_comb begin
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = acc_put && is_print;
      ram_waddr = wphys;
      ram_wdata = '{attr: attr_r, chr: in_if.char_code};
    end
  end

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc_rd && rd_in_range),
    .raddr (rd_phys),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sweep_addr_r == sweep_last_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc_rd) begin
          state_nxt = S_READ;
        end else if (acc_put && scroll) begin
          state_nxt = S_SCRUB;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      S_SCRUB: begin
        if (sweep_addr_r == sweep_last_r) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      col_r        <= '0;
      row_r        <= '0;
      hw_r         <= '0;
      top_base_r   <= '0;
      sweep_addr_r <= '0;
      sweep_last_r <= AW'(CELLS - 1);
      attr_r       <= ATTR_RESET;
      tab_r        <= TAB_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_ATTR: attr_r <= cfg_wdata;
          CFG_TAB_ADV:   tab_r  <= cfg_wdata[TAB_W-1:0];
          default: ;
        endcase
      end
      if (sweeping) begin
        sweep_addr_r <= sweep_addr_r + AW'(1);
      end
      if (acc_put) begin
        col_r <= col_c;
        row_r <= row_c;
        if (in_if.end_of_text) hw_r <= hw_nxt;
        if (scroll) begin
          top_base_r   <= top_base_nxt;
          sweep_addr_r <= top_base_r;
          sweep_last_r <= top_base_r + AW'(COLUMNS - 1);
        end
      end
      if (acc_put || state_r == S_READ) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (acc_rd) begin
      rd_zero_r <= !rd_in_range;
    end
    if (acc_put) begin
      out_if.cursor_col      <= COL_FLD_W'(col_c);
      out_if.cursor_row      <= ROW_FLD_W'(row_c);
      out_if.scrolled        <= scroll;
      out_if.cursor_written  <= in_if.end_of_text;
      out_if.cursor_position <= in_if.end_of_text ? POS_FLD_W'(hw_nxt) : POS_FLD_W'(hw_r);
      out_if.cell_char       <= '0;
      out_if.cell_attr       <= '0;
    end else if (state_r == S_READ) begin
      out_if.cursor_col      <= COL_FLD_W'(col_r);
      out_if.cursor_row      <= ROW_FLD_W'(row_r);
      out_if.scrolled        <= 1'b0;
      out_if.cursor_written  <= 1'b0;
      out_if.cursor_position <= POS_FLD_W'(hw_r);
      out_if.cell_char       <= rd_zero_r ? '0 : ram_rdata.chr;
      out_if.cell_attr       <= rd_zero_r ? '0 : ram_rdata.attr;
    end
  end

  assign out_if.valid = out_valid_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < COLUMNS) && (row_r < ROWS) && (top_base_r < CELLS))
    else $error("cursor or ring base out of range");

  a_scroll_scrub: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_put && scroll) |=> (state_r == S_SCRUB) && (sweep_addr_r == $past(top_base_r)))
    else $error("scroll did not start bottom row clear at old ring base");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_rd |-> ##2 out_valid_r)
    else $error("read word produced no result");

  a_no_put_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> !acc_in && (ram_waddr == sweep_addr_r))
    else $error("word accepted or stray write during clear");

endmodule

[hdl/tcw_screen_ram.sv]
// Screen cell memory: one write port, one registered read port.
module tcw_screen_ram import tcw_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
